FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the deque.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)

`define ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

FILE: hw/rtl/cdq_pkg.sv
// Shared types and constants of the circular deque.
// No dependencies; used by every module of the block.
package cdq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W = 32;
  localparam int ACT_W = 2;
  localparam int ST_W = 2;
  localparam int OCC_W = 5;
  localparam int M_TDATA_W = ((DATA_W + 1 + OCC_W + 7) / 8) * 8;

  localparam logic [ACT_W-1:0] ACT_PUSH_HEAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_TAIL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP_HEAD  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_TAIL  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } cdq_cmd_t;

  typedef struct packed {
    logic out_free;
  } cdq_stat_t;

endpackage

FILE: hw/rtl/cdq_ctrl.sv
// Sequencer of the circular deque: accept, execute, respond.
// Depends on cdq_pkg; drives the datapath through cdq_cmd_t.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  cdq_stat_t stat,
  output cdq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;
  logic   ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid && ready) begin
            state <= S_EXEC;
            ready <= 1'b0;
          end
        end
        S_EXEC: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (stat.out_free) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

  assign s_tready     = ready;
  assign cmd.load_in  = ready && s_tvalid;
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.load_out = (state == S_RESP) && stat.out_free;

endmodule

FILE: hw/rtl/cdq_dp.sv
// Datapath of the circular deque: ring memory, indices, count and output register.
// Depends on cdq_pkg and assert_macros.svh; sequenced by cdq_ctrl.
`include "assert_macros.svh"

module cdq_dp
  import cdq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cdq_cmd_t                 cmd,
  output cdq_stat_t                stat,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_popped,
  output logic [ST_W-1:0]          out_status,
  output logic                     out_empty,
  output logic [OCC_W-1:0]         out_occ
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [ACT_W-1:0]         act;
  logic signed [DATA_W-1:0] value;
  logic [IDX_W-1:0]         front;
  logic [IDX_W-1:0]         back;
  logic [CNT_W-1:0]         count;
  logic [DATA_W-1:0]        rd_data;
  logic [ST_W-1:0]          res_status;
  logic                     res_pop;

  logic             is_push;
  logic             is_full;
  logic             is_empty;
  logic             push_ok;
  logic             pop_ok;
  logic [IDX_W-1:0] addr;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act   <= in_action;
      value <= in_value;
    end
  end

  always_comb begin
    is_push  = (act == ACT_PUSH_HEAD) || (act == ACT_PUSH_TAIL);
    is_full  = (count == FULL_CNT);
    is_empty = (count == '0);
    push_ok  = cmd.exec && is_push && !is_full;
    pop_ok   = cmd.exec && !is_push && !is_empty;
    case (act)
      ACT_PUSH_HEAD: addr = wrap_dec(front);
      ACT_PUSH_TAIL: addr = back;
      ACT_POP_HEAD:  addr = front;
      ACT_POP_TAIL:  addr = wrap_dec(back);
      default:       addr = front;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[addr] <= value;
    end
    if (pop_ok) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        count <= count + CNT_W'(1);
        if (act == ACT_PUSH_HEAD) begin
          front <= addr;
        end else begin
          back <= wrap_inc(back);
        end
      end else if (pop_ok) begin
        count <= count - CNT_W'(1);
        if (act == ACT_POP_HEAD) begin
          front <= wrap_inc(front);
        end else begin
          back <= addr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_pop <= pop_ok;
      if (is_push) begin
        res_status <= is_full ? ST_FULL : ST_OK;
      end else begin
        res_status <= is_empty ? ST_EMPTY : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_popped <= res_pop ? signed'(rd_data) : '0;
      out_status <= res_status;
      out_empty  <= (count == '0);
      out_occ    <= OCC_W'(count);
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= FULL_CNT, "fill count above capacity")
  `ASSERT_ALWAYS(a_idx_match, clk, rst, (count == '0 || count == FULL_CNT) -> (front == back), "indices disagree with count")
  `ASSERT_NEXT(a_push_count, clk, rst, push_ok, count == $past(count) + CNT_W'(1), "push did not raise count")
  `ASSERT_NEXT(a_pop_count, clk, rst, pop_ok, count == $past(count) - CNT_W'(1), "pop did not lower count")

endmodule

FILE: hw/rtl/circular_deque.sv
// Circular double-ended queue: a fixed ring of CAPACITY 32-bit entries.
// The slave channel carries one request per transfer: s_tuser selects push at head,
// push at tail, pop at head or pop at tail, and s_tdata holds the value to push.
// The master channel returns exactly one response per request: m_tdata holds the
// popped value (zero for pushes and errors), the empty flag and the occupancy after
// the request, and m_tuser holds the status code.
// A pop on an empty deque reports an empty error, and a push on a full deque is
// dropped with a full error; neither changes the contents.
// Each request is accepted into the input register, then drives the single-port ring
// memory access and index update, and then loads the output register. The next
// request is accepted in the cycle after the response is loaded, so the block
// takes no new request before the response to the last one is loaded.
// When the receiver stalls, the response waits in the output register and at most
// one further request is taken and held until the register frees.
// Reset clears the indices and the count, so the deque starts empty; the ring
// memory is not cleared.
// Depends on cdq_pkg, cdq_ctrl and cdq_dp.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_W-1:0]     s_tdata,  // [31:0] item_value
  input  logic [ACT_W-1:0]      s_tuser,  // [1:0] action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // [31:0] popped_value, [32] is_empty, [37:33] occupancy
  output logic [ST_W-1:0]       m_tuser   // [1:0] status
);

  cdq_cmd_t                 cmd;
  cdq_stat_t                stat;
  logic signed [DATA_W-1:0] popped_value;
  logic [ST_W-1:0]          status;
  logic                     is_empty;
  logic [OCC_W-1:0]         occupancy;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (s_tuser),
    .in_value   (signed'(s_tdata)),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_popped (popped_value),
    .out_status (status),
    .out_empty  (is_empty),
    .out_occ    (occupancy)
  );

  assign m_tdata = M_TDATA_W'({occupancy, is_empty, unsigned'(popped_value)});
  assign m_tuser = status;

endmodule
